[rtl/tcpqs_pkg.sv]
// Shared types, constants and the class-selection function for the
// three-class priority queue scheduler. No dependencies.
package tcpqs_pkg;

  localparam int KEY_W           = 37;
  localparam int LVL_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int AHEAD_W         = 6;
  localparam int CNT_W           = 16;
  localparam int RUN_W           = 3;
  localparam int LIMIT_W         = 3;
  localparam int NUM_CLASSES     = 3;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;
  localparam logic [RUN_W-1:0]   RUN_MAX     = 3'd7;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
  localparam logic [AHEAD_W-1:0] AHEAD_MAX   = 6'd63;

  localparam logic [LVL_W-1:0] CLS_TOP  = 2'd0;
  localparam logic [LVL_W-1:0] CLS_MID  = 2'd1;
  localparam logic [LVL_W-1:0] CLS_LOW  = 2'd2;
  localparam logic [LVL_W-1:0] CLS_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_SERVE = 2'd1,
    REQ_FIND  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic srv_capture;
    logic sch_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic srv_empty;
    logic sch_done;
  } stat_t;

  function automatic logic [LVL_W-1:0] pick_class(input logic top_nz,
                                                  input logic mid_nz,
                                                  input logic low_nz,
                                                  input logic [RUN_W-1:0] run,
                                                  input logic [LIMIT_W-1:0] limit);
    logic [LIMIT_W-1:0] eff;
    logic [LVL_W-1:0]   cls;
    eff = (limit == '0) ? LIMIT_W'(1) : limit;
    if (top_nz) begin
      cls = CLS_TOP;
    end else if (mid_nz && ((run < eff) || !low_nz)) begin
      cls = CLS_MID;
    end else if (low_nz) begin
      cls = CLS_LOW;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

endpackage

[rtl/tcpqs_ctrl.sv]
// Controller state machine of the scheduler: sequences accept, execute,
// serve read, search walk and result hand-off. Depends on tcpqs_pkg.
module tcpqs_ctrl
  import tcpqs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SRV_RD   = 3'd2;
  localparam logic [2:0] ST_SEARCH   = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.exec = 1'b1;
        case (stat_i.req)
          REQ_SERVE: state_d = stat_i.srv_empty ? ST_FINISH : ST_SRV_RD;
          REQ_FIND:  state_d = ST_SEARCH;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_SRV_RD: begin
        cmd_o.srv_capture = 1'b1;
        state_d           = ST_FINISH;
      end
      ST_SEARCH: begin
        cmd_o.sch_step = 1'b1;
        if (stat_i.sch_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/tcpqs_dpath.sv]
// Datapath of the scheduler: the three key stores, queue pointers, run and
// served counters, the search walk registers and the result registers.
// Depends on tcpqs_pkg.
module tcpqs_dpath
  import tcpqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [LIMIT_W-1:0]  limit_i,
  input  logic [1:0]          req_type_i,
  input  logic [LVL_W-1:0]    priority_level_i,
  input  logic [KEY_W-1:0]    ident_key_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [LVL_W-1:0]    served_level_o,
  output logic [KEY_W-1:0]    served_key_o,
  output logic [AHEAD_W-1:0]  ahead_count_o,
  output logic [CNT_W-1:0]    served_top_o,
  output logic [CNT_W-1:0]    served_middle_o,
  output logic [CNT_W-1:0]    served_low_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] HEAD_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);

  req_e                req_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [KEY_W-1:0]    key_q;

  logic [PW-1:0]       head_q   [NUM_CLASSES];
  logic [FW-1:0]       fill_q   [NUM_CLASSES];
  logic [CNT_W-1:0]    cnt_q    [NUM_CLASSES];
  logic [RUN_W-1:0]    run_q;

  logic [PW-1:0]       whead_q  [NUM_CLASSES];
  logic [FW-1:0]       wfill_q  [NUM_CLASSES];
  logic [RUN_W-1:0]    wrun_q;
  logic [AHEAD_W-1:0]  wcount_q;
  logic                pend_q;
  logic [LVL_W-1:0]    rd_cls_q;

  logic [KEY_W-1:0]    rdata_q  [NUM_CLASSES];

  logic [STATUS_W-1:0] res_status_q;
  logic [LVL_W-1:0]    res_level_q;
  logic [KEY_W-1:0]    res_key_q;
  logic [AHEAD_W-1:0]  res_ahead_q;

  logic [STATUS_W-1:0] out_status_q;
  logic [LVL_W-1:0]    out_level_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [AHEAD_W-1:0]  out_ahead_q;
  logic [CNT_W-1:0]    out_top_q;
  logic [CNT_W-1:0]    out_mid_q;
  logic [CNT_W-1:0]    out_low_q;

  logic [NUM_CLASSES-1:0] nz, wnz, we, re;
  logic [PW-1:0]       waddr     [NUM_CLASSES];
  logic [PW-1:0]       raddr     [NUM_CLASSES];
  logic [PW-1:0]       head_inc  [NUM_CLASSES];
  logic [PW-1:0]       whead_inc [NUM_CLASSES];
  logic [SW-1:0]       wsum      [NUM_CLASSES];
  logic [LVL_W-1:0]    srv_cls, walk_cls;
  logic [KEY_W-1:0]    rsel;
  logic                match, srv_issue, walk_issue, enq_full, sch_done;

  always_comb begin
    rsel     = '0;
    enq_full = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nz[c]        = (fill_q[c] != '0);
      wnz[c]       = (wfill_q[c] != '0);
      wsum[c]      = SW'(head_q[c]) + SW'(fill_q[c]);
      waddr[c]     = (wsum[c] >= DEPTH_S) ? PW'(wsum[c] - DEPTH_S) : PW'(wsum[c]);
      head_inc[c]  = (head_q[c] == HEAD_LAST) ? '0 : head_q[c] + 1'b1;
      whead_inc[c] = (whead_q[c] == HEAD_LAST) ? '0 : whead_q[c] + 1'b1;
      if (rd_cls_q == LVL_W'(c)) begin
        rsel = rdata_q[c];
      end
      if (lvl_q == LVL_W'(c) && fill_q[c] == FILL_FULL) begin
        enq_full = 1'b1;
      end
    end
  end

  assign srv_cls    = pick_class(nz[0], nz[1], nz[2], run_q, limit_i);
  assign walk_cls   = pick_class(wnz[0], wnz[1], wnz[2], wrun_q, limit_i);
  assign match      = pend_q && (rsel == key_q);
  assign sch_done   = match || (!pend_q && walk_cls == CLS_NONE);
  assign srv_issue  = cmd_i.exec && (req_q == REQ_SERVE) && (srv_cls != CLS_NONE);
  assign walk_issue = cmd_i.sch_step && !match && (walk_cls != CLS_NONE);

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      we[c]    = cmd_i.exec && (req_q == REQ_ENQ) && (lvl_q == LVL_W'(c)) &&
                 (fill_q[c] != FILL_FULL);
      re[c]    = (srv_issue && srv_cls == LVL_W'(c)) ||
                 (walk_issue && walk_cls == LVL_W'(c));
      raddr[c] = srv_issue ? head_q[c] : whead_q[c];
    end
  end

  assign stat_o.req       = req_q;
  assign stat_o.srv_empty = (srv_cls == CLS_NONE);
  assign stat_o.sch_done  = sch_done;

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_store
    logic [KEY_W-1:0] store_q [QUEUE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (we[c]) begin
        store_q[waddr[c]] <= key_q;
      end
      if (re[c]) begin
        rdata_q[c] <= store_q[raddr[c]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= '0;
        fill_q[c]  <= '0;
        cnt_q[c]   <= '0;
        whead_q[c] <= '0;
        wfill_q[c] <= '0;
      end
      run_q    <= '0;
      wrun_q   <= '0;
      wcount_q <= '0;
      pend_q   <= 1'b0;
      rd_cls_q <= CLS_TOP;
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (we[c]) begin
          fill_q[c] <= fill_q[c] + 1'b1;
        end
      end
      if (srv_issue) begin
        rd_cls_q <= srv_cls;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (srv_cls == LVL_W'(c)) begin
            head_q[c] <= head_inc[c];
            fill_q[c] <= fill_q[c] - 1'b1;
            if (cnt_q[c] != CNT_MAX) begin
              cnt_q[c] <= cnt_q[c] + 1'b1;
            end
          end
        end
        if (srv_cls == CLS_MID) begin
          if (run_q != RUN_MAX) begin
            run_q <= run_q + 1'b1;
          end
        end else if (srv_cls == CLS_LOW) begin
          run_q <= '0;
        end
      end
      if (cmd_i.exec && req_q == REQ_FIND) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          whead_q[c] <= head_q[c];
          wfill_q[c] <= fill_q[c];
        end
        wrun_q   <= '0;
        wcount_q <= '0;
        pend_q   <= 1'b0;
      end
      if (cmd_i.sch_step && !match) begin
        if (pend_q && wcount_q != AHEAD_MAX) begin
          wcount_q <= wcount_q + 1'b1;
        end
        pend_q <= walk_issue;
        if (walk_issue) begin
          rd_cls_q <= walk_cls;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (walk_cls == LVL_W'(c)) begin
              whead_q[c] <= whead_inc[c];
              wfill_q[c] <= wfill_q[c] - 1'b1;
            end
          end
          if (walk_cls == CLS_MID) begin
            if (wrun_q != RUN_MAX) begin
              wrun_q <= wrun_q + 1'b1;
            end
          end else if (walk_cls == CLS_LOW) begin
            wrun_q <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_e'(req_type_i);
      lvl_q <= priority_level_i;
      key_q <= ident_key_i;
    end
    if (cmd_i.exec) begin
      res_key_q   <= '0;
      res_ahead_q <= '0;
      res_level_q <= '0;
      res_status_q <= STAT_OK;
      if (req_q == REQ_ENQ && enq_full) begin
        res_status_q <= STAT_FULL;
      end
      if (req_q == REQ_SERVE) begin
        if (srv_cls == CLS_NONE) begin
          res_status_q <= STAT_EMPTY;
        end else begin
          res_level_q <= srv_cls;
        end
      end
    end
    if (cmd_i.srv_capture) begin
      res_key_q <= rsel;
    end
    if (cmd_i.sch_step && sch_done) begin
      if (match) begin
        res_ahead_q <= wcount_q;
      end else begin
        res_status_q <= STAT_NOTFOUND;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_level_q  <= res_level_q;
      out_key_q    <= res_key_q;
      out_ahead_q  <= res_ahead_q;
      out_top_q    <= cnt_q[0];
      out_mid_q    <= cnt_q[1];
      out_low_q    <= cnt_q[2];
    end
  end

  assign status_o        = out_status_q;
  assign served_level_o  = out_level_q;
  assign served_key_o    = out_key_q;
  assign ahead_count_o   = out_ahead_q;
  assign served_top_o    = out_top_q;
  assign served_middle_o = out_mid_q;
  assign served_low_o    = out_low_q;

endmodule

[rtl/three_class_priority_queue_scheduler.sv]
// Top level of the three-class priority queue scheduler: configuration
// register port, controller and datapath. Depends on tcpqs_pkg, tcpqs_ctrl
// and tcpqs_dpath.
//
// The block holds three FIFO queues of 37-bit keys and handles one request
// at a time. A serve reads its key from a store with a registered read port.
// A search walks the projected serve order one store read per cycle and reads
// at most 3 * QUEUE_DEPTH keys before the match or the end of the walk.
// A result that is stalled at the output does not block acceptance of the
// next request, but that request waits in its final cycle until the output
// register frees, and no further request is accepted meanwhile. The
// middle_run_limit register lies at byte address 0; a value of 0 behaves
// as 1. No clearing pass runs after reset.
module three_class_priority_queue_scheduler
  import tcpqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [LVL_W-1:0]      priority_level_i,
  input  logic [KEY_W-1:0]      ident_key_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [LVL_W-1:0]      served_level_o,
  output logic [KEY_W-1:0]      served_key_o,
  output logic [AHEAD_W-1:0]    ahead_count_o,
  output logic [CNT_W-1:0]      served_top_o,
  output logic [CNT_W-1:0]      served_middle_o,
  output logic [CNT_W-1:0]      served_low_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LIMIT_W-1:0] limit_q;
  logic               limit_sel;
  logic               cfg_wr;
  cmd_t               cmd;
  stat_t              stat;

  assign pready    = 1'b1;
  assign limit_sel = (paddr[APB_ADDR_W-1] == 1'b0);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = limit_sel ? APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr && limit_sel) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  tcpqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcpqs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .limit_i          (limit_q),
    .req_type_i       (req_type_i),
    .priority_level_i (priority_level_i),
    .ident_key_i      (ident_key_i),
    .status_o         (status_o),
    .served_level_o   (served_level_o),
    .served_key_o     (served_key_o),
    .ahead_count_o    (ahead_count_o),
    .served_top_o     (served_top_o),
    .served_middle_o  (served_middle_o),
    .served_low_o     (served_low_o)
  );

  // Only one request is in flight: an accepted beat closes the input side.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a request was in flight");

  // A new output beat appears only from a result load by the controller.
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("output valid rose without a result load");

  // A completed register write is visible in the following cycle.
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && limit_sel) |=> (limit_q == $past(pwdata[LIMIT_W-1:0])))
    else $error("run limit register not updated by write");

  // Load/latch and exec/sch_step never coincide: result precedes next request.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load_out && cmd.latch) && !(cmd.exec && cmd.sch_step))
    else $error("conflicting controller commands");

endmodule
